// ----- hdl/adp_alu_pkg.sv -----
package adp_alu_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ClzW  = 6;
  localparam int unsigned ByteW = 8;
  localparam int unsigned LzByteW = 4;

  localparam logic [DataW-1:0] SatMax = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] SatMin = 32'h8000_0000;

  // Operation codes on in_op
  typedef enum logic [3:0] {
    OP_AND  = 4'd0,
    OP_BIC  = 4'd1,
    OP_EOR  = 4'd2,
    OP_ORR  = 4'd3,
    OP_MOV  = 4'd4,
    OP_MVN  = 4'd5,
    OP_ADD  = 4'd6,
    OP_ADC  = 4'd7,
    OP_SUB  = 4'd8,
    OP_RSB  = 4'd9,
    OP_SBC  = 4'd10,
    OP_RSC  = 4'd11,
    OP_CLZ  = 4'd12,
    OP_QADD = 4'd13,
    OP_QSUB = 4'd14
  } op_t;

  // Result class carried down the pipe
  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_LOGIC = 3'd1,
    KIND_ARITH = 3'd2,
    KIND_CLZ   = 3'd3,
    KIND_SAT   = 3'd4
  } kind_t;

  // Leading zeros of one byte, 8 for a zero byte
  function automatic logic [LzByteW-1:0] lz_byte(input logic [ByteW-1:0] b);
    logic [LzByteW-1:0] n;
    logic               found;
    n     = LzByteW'(ByteW);
    found = 1'b0;
    for (int i = ByteW - 1; i >= 0; i--) begin
      if (!found && b[i]) begin
        n     = LzByteW'(ByteW - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// ----- hdl/arm_data_processing_alu_top.sv -----
// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+---------------------------
// input     | in_op, in_first_operand, in_second_operand,  | transfer when start && !busy
//           | in_carry_in, in_overflow_in, in_set_flags     |
// result    | out_value_out, out_*_flag, out_saturated      | out_valid, one cycle, no stall
//
// Three register stages: operand setup and byte CLZ, 33-bit add and CLZ merge,
// saturation and flags into the output register. One operation can be taken
// every cycle, so busy stays low. Reset (rst_n low, synchronous) clears the
// stage valid bits only.
// The receiver cannot stall, so nothing ever holds in the pipe.
module arm_data_processing_alu_top
  import adp_alu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [3:0]       in_op,
  input  logic [DataW-1:0] in_first_operand,
  input  logic [DataW-1:0] in_second_operand,
  input  logic             in_carry_in,
  input  logic             in_overflow_in,
  input  logic             in_set_flags,
  output logic             out_valid,
  output logic [DataW-1:0] out_value_out,
  output logic             out_negative_flag,
  output logic             out_zero_flag,
  output logic             out_carry_flag,
  output logic             out_overflow_flag,
  output logic             out_saturated
);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------- stage 1: decode and operand setup ----------------
  logic             v1_r;
  kind_t            kind1_r, kind1_nxt;
  logic [DataW-1:0] x1_r, x1_nxt, y1_r, y1_nxt, lres1_r, lres1_nxt;
  logic             c1_r, c1_nxt;
  logic [LzByteW-1:0] lz1_r [4];
  logic [3:0]       nz1_r;
  logic             cin1_r, vin1_r, sf1_r;

  always_comb begin
    kind1_nxt = KIND_NONE;
    x1_nxt    = in_first_operand;
    y1_nxt    = in_second_operand;
    c1_nxt    = 1'b0;
    lres1_nxt = '0;
    case (in_op)
      OP_AND:  begin kind1_nxt = KIND_LOGIC; lres1_nxt = in_first_operand & in_second_operand; end
      OP_BIC:  begin kind1_nxt = KIND_LOGIC; lres1_nxt = in_first_operand & ~in_second_operand; end
      OP_EOR:  begin kind1_nxt = KIND_LOGIC; lres1_nxt = in_first_operand ^ in_second_operand; end
      OP_ORR:  begin kind1_nxt = KIND_LOGIC; lres1_nxt = in_first_operand | in_second_operand; end
      OP_MOV:  begin kind1_nxt = KIND_LOGIC; lres1_nxt = in_first_operand; end
      OP_MVN:  begin kind1_nxt = KIND_LOGIC; lres1_nxt = ~in_first_operand; end
      OP_ADD:  kind1_nxt = KIND_ARITH;
      OP_ADC:  begin kind1_nxt = KIND_ARITH; c1_nxt = in_carry_in; end
      OP_SUB:  begin kind1_nxt = KIND_ARITH; y1_nxt = ~in_second_operand; c1_nxt = 1'b1; end
      OP_RSB:  begin
        kind1_nxt = KIND_ARITH;
        x1_nxt    = in_second_operand;
        y1_nxt    = ~in_first_operand;
        c1_nxt    = 1'b1;
      end
      OP_SBC:  begin kind1_nxt = KIND_ARITH; y1_nxt = ~in_second_operand; c1_nxt = in_carry_in; end
      OP_RSC:  begin
        kind1_nxt = KIND_ARITH;
        x1_nxt    = in_second_operand;
        y1_nxt    = ~in_first_operand;
        c1_nxt    = in_carry_in;
      end
      OP_CLZ:  kind1_nxt = KIND_CLZ;
      OP_QADD: kind1_nxt = KIND_SAT;
      OP_QSUB: begin kind1_nxt = KIND_SAT; y1_nxt = ~in_second_operand; c1_nxt = 1'b1; end
      default: kind1_nxt = KIND_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  // Capture decoded operands and per-byte leading-zero counts
  always_ff @(posedge clk) begin
    kind1_r <= kind1_nxt;
    x1_r    <= x1_nxt;
    y1_r    <= y1_nxt;
    c1_r    <= c1_nxt;
    lres1_r <= lres1_nxt;
    cin1_r  <= in_carry_in;
    vin1_r  <= in_overflow_in;
    sf1_r   <= in_set_flags;
    for (int i = 0; i < 4; i++) begin
      lz1_r[i] <= lz_byte(in_first_operand[i*ByteW +: ByteW]);
      nz1_r[i] <= |in_first_operand[i*ByteW +: ByteW];
    end
  end

  // ---------------- stage 2: add, CLZ merge, result select ----------------
  logic             v2_r;
  kind_t            kind2_r;
  logic [DataW-1:0] res2_r, res2_nxt;
  logic             co2_r, ov2_r, ov2_nxt;
  logic             cin2_r, vin2_r, sf2_r;
  logic [DataW:0]   sum2;
  logic [ClzW-1:0]  clz2;

  assign sum2    = {1'b0, x1_r} + {1'b0, y1_r} + {{DataW{1'b0}}, c1_r};
  assign ov2_nxt = (x1_r[DataW-1] ^ sum2[DataW-1]) & (y1_r[DataW-1] ^ sum2[DataW-1]);

  // Merge byte counts from the top byte down
  always_comb begin
    if (nz1_r[3])      clz2 = ClzW'(lz1_r[3]);
    else if (nz1_r[2]) clz2 = ClzW'(lz1_r[2]) + ClzW'(8);
    else if (nz1_r[1]) clz2 = ClzW'(lz1_r[1]) + ClzW'(16);
    else if (nz1_r[0]) clz2 = ClzW'(lz1_r[0]) + ClzW'(24);
    else               clz2 = ClzW'(DataW);
  end

  always_comb begin
    case (kind1_r)
      KIND_LOGIC: res2_nxt = lres1_r;
      KIND_ARITH: res2_nxt = sum2[DataW-1:0];
      KIND_SAT:   res2_nxt = sum2[DataW-1:0];
      KIND_CLZ:   res2_nxt = DataW'(clz2);
      default:    res2_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    kind2_r <= kind1_r;
    res2_r  <= res2_nxt;
    co2_r   <= sum2[DataW];
    ov2_r   <= ov2_nxt;
    cin2_r  <= cin1_r;
    vin2_r  <= vin1_r;
    sf2_r   <= sf1_r;
  end

  // ---------------- stage 3: saturate, flags, output register ----------------
  logic             out_valid_r;
  logic [DataW-1:0] value_r, value_nxt;
  logic             n_r, n_nxt, z_r, z_nxt, c_r, c_nxt, v_r, v_nxt, sat_r, sat_nxt;
  logic             upd3;

  assign upd3 = sf2_r && (kind2_r == KIND_LOGIC || kind2_r == KIND_ARITH);

  always_comb begin
    value_nxt = res2_r;
    sat_nxt   = 1'b0;
    if (kind2_r == KIND_SAT && ov2_r) begin
      // wrapped sign set means the true result was positive
      value_nxt = res2_r[DataW-1] ? SatMax : SatMin;
      sat_nxt   = 1'b1;
    end
    n_nxt = 1'b0;
    z_nxt = 1'b0;
    c_nxt = cin2_r;
    v_nxt = vin2_r;
    if (upd3) begin
      n_nxt = res2_r[DataW-1];
      z_nxt = (res2_r == '0);
      if (kind2_r == KIND_ARITH) begin
        c_nxt = co2_r;
        v_nxt = ov2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    n_r     <= n_nxt;
    z_r     <= z_nxt;
    c_r     <= c_nxt;
    v_r     <= v_nxt;
    sat_r   <= sat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_value_out     = value_r;
  assign out_negative_flag = n_r;
  assign out_zero_flag     = z_r;
  assign out_carry_flag    = c_r;
  assign out_overflow_flag = v_r;
  assign out_saturated     = sat_r;

  // ---------------- assertions ----------------
  // Every transfer produces exactly one result strobe on out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3)) |->
      (out_valid == $past(accept, 3)))
    else $error("result strobe does not match transfer three cycles earlier");

  // A clamped result is one of the two signed limits
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_value_out == SatMax || out_value_out == SatMin))
    else $error("saturated result is not a signed limit");

  // Saturating ops never update N or Z
  a_sat_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (!out_negative_flag && !out_zero_flag))
    else $error("saturating op changed N or Z");

endmodule

// ----- tb/adp_alu_checker.sv -----
module adp_alu_checker
  import adp_alu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [3:0]       in_op,
  input  logic [DataW-1:0] in_first_operand,
  input  logic [DataW-1:0] in_second_operand,
  input  logic             in_carry_in,
  input  logic             in_overflow_in,
  input  logic             in_set_flags,
  input  logic             out_valid,
  input  logic [DataW-1:0] out_value_out,
  input  logic             out_negative_flag,
  input  logic             out_zero_flag,
  input  logic             out_carry_flag,
  input  logic             out_overflow_flag,
  input  logic             out_saturated,
  input  logic             end_of_test,
  output int               err_count,
  output int               outstanding,
  output int               results_checked
);

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             neg;
    logic             zero;
    logic             carry;
    logic             ovf;
    logic             sat;
  } alu_result_t;

  alu_result_t pending_results[$];
  alu_result_t want;
  logic        leftover_done;

  initial begin
    err_count       = 0;
    outstanding     = 0;
    results_checked = 0;
    leftover_done   = 1'b0;
  end

  // Compute value, flags and saturation mark for one operation
  function automatic alu_result_t alu_predict(input logic [3:0] op,
                                              input logic [DataW-1:0] a,
                                              input logic [DataW-1:0] b,
                                              input logic cin,
                                              input logic vin,
                                              input logic sf);
    alu_result_t      res;
    logic [DataW:0]   wide;
    logic [DataW-1:0] r;
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic             ci;
    logic             sum_c;
    logic             sum_v;
    logic             is_logic;
    logic             is_arith;
    logic             is_sat;
    logic             found;
    int               lz;
    r        = '0;
    x        = '0;
    y        = '0;
    ci       = 1'b0;
    sum_c    = 1'b0;
    sum_v    = 1'b0;
    is_logic = 1'b0;
    is_arith = 1'b0;
    is_sat   = 1'b0;
    case (op)
      OP_AND:  begin r = a & b;  is_logic = 1'b1; end
      OP_BIC:  begin r = a & ~b; is_logic = 1'b1; end
      OP_EOR:  begin r = a ^ b;  is_logic = 1'b1; end
      OP_ORR:  begin r = a | b;  is_logic = 1'b1; end
      OP_MOV:  begin r = a;      is_logic = 1'b1; end
      OP_MVN:  begin r = ~a;     is_logic = 1'b1; end
      OP_ADD:  begin x = a; y = b;  ci = 1'b0; is_arith = 1'b1; end
      OP_ADC:  begin x = a; y = b;  ci = cin;  is_arith = 1'b1; end
      OP_SUB:  begin x = a; y = ~b; ci = 1'b1; is_arith = 1'b1; end
      OP_RSB:  begin x = b; y = ~a; ci = 1'b1; is_arith = 1'b1; end
      OP_SBC:  begin x = a; y = ~b; ci = cin;  is_arith = 1'b1; end
      OP_RSC:  begin x = b; y = ~a; ci = cin;  is_arith = 1'b1; end
      OP_CLZ: begin
        lz    = 0;
        found = 1'b0;
        for (int i = DataW - 1; i >= 0; i--) begin
          if (!found) begin
            if (a[i]) found = 1'b1;
            else lz++;
          end
        end
        r = lz;
      end
      OP_QADD: begin x = a; y = b;  ci = 1'b0; is_sat = 1'b1; end
      OP_QSUB: begin x = a; y = ~b; ci = 1'b1; is_sat = 1'b1; end
      default: r = '0;
    endcase

    // Shared adder with ARM carry and signed overflow
    if (is_arith || is_sat) begin
      wide  = {1'b0, x} + {1'b0, y} + {{DataW{1'b0}}, ci};
      r     = wide[DataW-1:0];
      sum_c = wide[DataW];
      sum_v = (x[DataW-1] ^ r[DataW-1]) & (y[DataW-1] ^ r[DataW-1]);
    end

    // Clamp: a wrapped negative sum means the true result was positive
    res.sat = 1'b0;
    if (is_sat && sum_v) begin
      r       = r[DataW-1] ? SatMax : SatMin;
      res.sat = 1'b1;
    end

    res.value = r;
    res.neg   = 1'b0;
    res.zero  = 1'b0;
    res.carry = cin;
    res.ovf   = vin;
    if (sf && (is_logic || is_arith)) begin
      res.neg  = r[DataW-1];
      res.zero = (r == '0);
      if (is_arith) begin
        res.carry = sum_c;
        res.ovf   = sum_v;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DataW-1:0] exp_v,
                                 input logic [DataW-1:0] got_v);
    $display("MISMATCH at result %0d: %s expected %h got %h",
             results_checked, what, exp_v, got_v);
    err_count++;
  endtask

  // Queue a prediction per input transfer, compare each result transfer
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      pending_results.push_back(alu_predict(in_op, in_first_operand, in_second_operand,
                                            in_carry_in, in_overflow_in, in_set_flags));
    end
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, value", '0, out_value_out);
      end else begin
        want = pending_results.pop_front();
        if (out_value_out !== want.value)
          report_mismatch("value", want.value, out_value_out);
        if (out_negative_flag !== want.neg)
          report_mismatch("N flag", DataW'(want.neg), DataW'(out_negative_flag));
        if (out_zero_flag !== want.zero)
          report_mismatch("Z flag", DataW'(want.zero), DataW'(out_zero_flag));
        if (out_carry_flag !== want.carry)
          report_mismatch("C flag", DataW'(want.carry), DataW'(out_carry_flag));
        if (out_overflow_flag !== want.ovf)
          report_mismatch("V flag", DataW'(want.ovf), DataW'(out_overflow_flag));
        if (out_saturated !== want.sat)
          report_mismatch("saturation mark", DataW'(want.sat), DataW'(out_saturated));
        results_checked++;
      end
    end
    // Flag predictions still waiting once the run is over
    if (end_of_test && !leftover_done) begin
      leftover_done = 1'b1;
      if (pending_results.size() != 0)
        report_mismatch("results never delivered, count", DataW'(pending_results.size()),
                        '0);
    end
    outstanding <= pending_results.size();
  end

endmodule

// ----- tb/tb_arm_data_processing_alu_top.sv -----
module tb_arm_data_processing_alu_top;
  import adp_alu_pkg::*;

  localparam logic [3:0] OpUnused   = 4'd15;
  localparam int         IdleLimit  = 1000;
  localparam int         PhaseItems = 163;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [3:0]       in_op;
  logic [DataW-1:0] in_first_operand;
  logic [DataW-1:0] in_second_operand;
  logic             in_carry_in;
  logic             in_overflow_in;
  logic             in_set_flags;
  logic             out_valid;
  logic [DataW-1:0] out_value_out;
  logic             out_negative_flag;
  logic             out_zero_flag;
  logic             out_carry_flag;
  logic             out_overflow_flag;
  logic             out_saturated;
  logic             end_of_test;

  int err_count;
  int outstanding;
  int results_checked;
  int issued;
  int idle_cycles;
  int idle_pcts[4] = '{0, 59, 0, 37};

  arm_data_processing_alu_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_first_operand  (in_first_operand),
    .in_second_operand (in_second_operand),
    .in_carry_in       (in_carry_in),
    .in_overflow_in    (in_overflow_in),
    .in_set_flags      (in_set_flags),
    .out_valid         (out_valid),
    .out_value_out     (out_value_out),
    .out_negative_flag (out_negative_flag),
    .out_zero_flag     (out_zero_flag),
    .out_carry_flag    (out_carry_flag),
    .out_overflow_flag (out_overflow_flag),
    .out_saturated     (out_saturated)
  );

  adp_alu_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_first_operand  (in_first_operand),
    .in_second_operand (in_second_operand),
    .in_carry_in       (in_carry_in),
    .in_overflow_in    (in_overflow_in),
    .in_set_flags      (in_set_flags),
    .out_valid         (out_valid),
    .out_value_out     (out_value_out),
    .out_negative_flag (out_negative_flag),
    .out_zero_flag     (out_zero_flag),
    .out_carry_flag    (out_carry_flag),
    .out_overflow_flag (out_overflow_flag),
    .out_saturated     (out_saturated),
    .end_of_test       (end_of_test),
    .err_count         (err_count),
    .outstanding       (outstanding),
    .results_checked   (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run when no transfer happens for too long
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Present one operation and hold it until it transfers
  task automatic send_op(input logic [3:0] op, input logic [DataW-1:0] a,
                         input logic [DataW-1:0] b, input logic cin, input logic vin,
                         input logic sf);
    @(negedge clk);
    start             <= 1'b1;
    in_op             <= op;
    in_first_operand  <= a;
    in_second_operand <= b;
    in_carry_in       <= cin;
    in_overflow_in    <= vin;
    in_set_flags      <= sf;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
  endtask

  // With a chance of pct percent, drop start for a random gap with noise on the operand lines
  task automatic idle_gap(input int pct);
    int n;
    if ($urandom_range(99) < pct) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 3);
      @(negedge clk);
      start             <= 1'b0;
      in_op             <= 4'($urandom);
      in_first_operand  <= $urandom;
      in_second_operand <= $urandom;
      in_carry_in       <= 1'($urandom);
      in_overflow_in    <= 1'($urandom);
      in_set_flags      <= 1'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return SatMax;
      3:       return SatMin;
      4:       return $urandom_range(0, 15);
      5:       return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_op             = OP_AND;
    in_first_operand  = '0;
    in_second_operand = '0;
    in_carry_in       = 1'b0;
    in_overflow_in    = 1'b0;
    in_set_flags      = 1'b0;
    end_of_test       = 1'b0;
    issued            = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: logic ops, kept flags, carry and overflow edges
    send_op(OP_AND, '1, '1, 1'b1, 1'b1, 1'b1);
    send_op(OP_BIC, 32'hF0F0_F0F0, 32'hFF00_FF00, 1'b0, 1'b1, 1'b1);
    send_op(OP_EOR, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1, 1'b0, 1'b1);
    send_op(OP_ORR, '0, '0, 1'b0, 1'b0, 1'b1);
    send_op(OP_MOV, SatMin, '0, 1'b1, 1'b1, 1'b1);
    send_op(OP_MVN, '0, '1, 1'b0, 1'b0, 1'b1);
    idle_gap(30);
    send_op(OP_ADD, '1, 32'h1, 1'b0, 1'b0, 1'b1);
    send_op(OP_ADD, SatMax, 32'h1, 1'b0, 1'b0, 1'b1);
    send_op(OP_ADC, '1, '0, 1'b1, 1'b0, 1'b1);
    send_op(OP_SUB, '0, 32'h1, 1'b1, 1'b0, 1'b1);
    send_op(OP_SUB, SatMin, 32'h1, 1'b0, 1'b0, 1'b1);
    send_op(OP_RSB, 32'h5, 32'h3, 1'b0, 1'b1, 1'b1);
    send_op(OP_SBC, 32'h5, 32'h5, 1'b0, 1'b0, 1'b1);
    send_op(OP_RSC, 32'h1, 32'h1, 1'b1, 1'b0, 1'b1);
    idle_gap(30);
    // Directed: count of zero, single-bit extremes, clamping both ways
    send_op(OP_CLZ, '0, '1, 1'b0, 1'b0, 1'b1);
    send_op(OP_CLZ, 32'h1, '0, 1'b1, 1'b1, 1'b0);
    send_op(OP_CLZ, SatMin, '0, 1'b0, 1'b1, 1'b1);
    send_op(OP_QADD, SatMax, 32'h1, 1'b0, 1'b0, 1'b0);
    send_op(OP_QADD, SatMin, SatMin, 1'b1, 1'b1, 1'b1);
    send_op(OP_QSUB, SatMin, 32'h1, 1'b0, 1'b1, 1'b0);
    send_op(OP_QSUB, SatMax, '1, 1'b1, 1'b0, 1'b1);
    send_op(OpUnused, '1, '1, 1'b1, 1'b1, 1'b1);
    send_op(OP_QADD, 32'h10, 32'h20, 1'b1, 1'b1, 1'b1);
    send_op(OP_ADD, 32'h2, 32'h3, 1'b1, 1'b1, 1'b0);
    send_op(OP_ORR, 32'h8000_0001, '0, 1'b1, 1'b1, 1'b1);

    // Random operations, one phase per sender idle rate
    foreach (idle_pcts[p]) begin
      for (int i = 0; i < PhaseItems; i++) begin
        idle_gap(idle_pcts[p]);
        send_op(4'($urandom_range(15)), pick_operand(), pick_operand(),
                1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end

    @(negedge clk);
    start <= 1'b0;

    // Drain the pipe, then let the checker flag leftovers
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Covered %0d operations: directed extremes and all 16 opcode values, then random",
             issued);
    $display("operands at sender idle rates of 0, 59, 0 and 37 percent; %0d results compared",
             results_checked);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
